// ----- rtl/core/alhf_pkg.sv -----
// ----------------------------------------------------------------------------
// alhf_pkg
// shared types and constants of the alert led hold and flash controller
// ----------------------------------------------------------------------------
package alhf_pkg;

    localparam int TIME_W    = 64;
    localparam int HOLD_W    = 40;
    localparam int HALF_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 40;
    localparam int MODE_W    = 2;
    localparam int DIV_CNT_W = 6;

    // item modes
    localparam logic [MODE_W-1:0] MODE_FRAME  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OFF    = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

    localparam logic [HOLD_W-1:0] HOLD_RST    = 40'd500000000;
    localparam logic [HALF_W-1:0] HALF_RST    = 32'd250000000;
    localparam logic [HOLD_W-1:0] TIMEOUT_RST = 40'd1000000000;

    // shared unit operations
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic              op;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [TIME_W-1:0] result;
        logic              borrow;
    } t_alu_rsp;

endpackage

// ----- rtl/core/alhf_alu.sv -----
// ----------------------------------------------------------------------------
// alhf_alu
// shared 64-bit add / subtract-compare unit
// ----------------------------------------------------------------------------
module alhf_alu (
    input  alhf_pkg::t_alu_req i_req,
    output alhf_pkg::t_alu_rsp o_rsp
);

    logic                        w_sub;
    logic [alhf_pkg::TIME_W-1:0] w_b;
    logic [alhf_pkg::TIME_W:0]   w_sum;

    assign w_sub = (i_req.op == alhf_pkg::ALU_SUB);
    assign w_b   = w_sub ? ~i_req.b : i_req.b;
    // subtract as a + ~b + 1, no carry out means a borrow
    assign w_sum = {1'b0, i_req.a} + {1'b0, w_b}
                 + {{alhf_pkg::TIME_W{1'b0}}, w_sub};

    assign o_rsp.result = w_sum[alhf_pkg::TIME_W-1:0];
    assign o_rsp.borrow = w_sub & ~w_sum[alhf_pkg::TIME_W];

endmodule

// ----- rtl/core/alert_led_hold_flash_controller.sv -----
// ----------------------------------------------------------------------------
// alert_led_hold_flash_controller
// drives the gap and speed alert leds from timestamped frame, update and
// all-off beats through one shared 64-bit add / subtract unit
// ----------------------------------------------------------------------------
// sequence: an all-off beat goes straight to the result slot; an update runs
// age, watchdog, gap and approach compares and, when its speed led flashes, a
// flash difference and 64 restoring divide steps first; frames give no result
// flow: one beat at a time, ready only when idle; a stall of the result slot
// holds off the next beat after an update or all-off beat
// reset: synchronous active low, registers to their defaults, block state cleared
module alert_led_hold_flash_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration beats
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [alhf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [alhf_pkg::CFG_DAT_W-1:0] i_cfg_data,
    // input beats
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [alhf_pkg::MODE_W-1:0]    i_mode,
    input  logic [alhf_pkg::TIME_W-1:0]    i_now_ns,
    input  logic                           i_gap_violation,
    input  logic                           i_approach_alert,
    // result beats
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_gap_led,
    output logic                           o_speed_led,
    output logic                           o_gap_changed,
    output logic                           o_speed_changed
);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_F_ADD = 4'd1;   // until = now + hold
    localparam logic [3:0] S_F_GAP = 4'd2;   // raise gap deadline
    localparam logic [3:0] S_F_APR = 4'd3;   // raise approach deadline
    localparam logic [3:0] S_U_AGE = 4'd4;   // frame age
    localparam logic [3:0] S_U_TMO = 4'd5;   // watchdog compare
    localparam logic [3:0] S_U_GAP = 4'd6;   // gap hold compare
    localparam logic [3:0] S_U_APR = 4'd7;   // approach hold compare
    localparam logic [3:0] S_U_DIF = 4'd8;   // time since flash start
    localparam logic [3:0] S_U_DIV = 4'd9;   // restoring divide steps
    localparam logic [3:0] S_OUT   = 4'd10;  // wait for the result slot

    // configuration
    logic [alhf_pkg::HOLD_W-1:0] r_hold;
    logic [alhf_pkg::HALF_W-1:0] r_half;
    logic [alhf_pkg::HOLD_W-1:0] r_tmo;

    // block state
    logic [3:0]                  r_state;
    logic [alhf_pkg::TIME_W-1:0] r_last;
    logic                        r_seen;
    logic                        r_gap_flag;
    logic                        r_apr_flag;
    logic [alhf_pkg::TIME_W-1:0] r_gap_dl;
    logic [alhf_pkg::TIME_W-1:0] r_apr_dl;
    logic [alhf_pkg::TIME_W-1:0] r_fstart;
    logic                        r_was;
    logic                        r_gap_lvl;
    logic                        r_spd_lvl;
    logic                        r_o_valid;

    // working registers
    logic [alhf_pkg::TIME_W-1:0]    r_now;
    logic                           r_gv;
    logic                           r_aa;
    logic [alhf_pkg::TIME_W-1:0]    r_tmp;     // until, age or dividend
    logic                           r_back;
    logic                           r_alive;
    logic                           r_gap_new;
    logic                           r_spd_new;
    logic [alhf_pkg::HALF_W-1:0]    r_rem;
    logic [alhf_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_o_gap;
    logic                           r_o_spd;
    logic                           r_o_gap_chg;
    logic                           r_o_spd_chg;

    alhf_pkg::t_alu_req w_req;
    alhf_pkg::t_alu_rsp w_rsp;
    logic               w_in_acc;
    logic               w_slot_free;
    logic               w_appr;
    logic [alhf_pkg::HALF_W:0] w_shift;

    assign o_cfg_ready     = 1'b1;
    assign o_ready         = (r_state == S_IDLE);
    assign w_in_acc        = i_valid & o_ready;
    assign w_slot_free     = ~r_o_valid | i_ready;
    assign o_valid         = r_o_valid;
    assign o_gap_led       = r_o_gap;
    assign o_speed_led     = r_o_spd;
    assign o_gap_changed   = r_o_gap_chg;
    assign o_speed_changed = r_o_spd_chg;

    // remainder shifted left with the next dividend bit
    assign w_shift = {r_rem, r_tmp[alhf_pkg::TIME_W-1]};
    // approach alert from the hold compare in S_U_APR
    assign w_appr  = r_alive & (r_apr_flag | w_rsp.borrow);

    // operand selection for the shared unit
    always_comb begin
        w_req.op = alhf_pkg::ALU_SUB;
        w_req.a  = r_now;
        w_req.b  = r_last;
        unique case (r_state)
            S_F_ADD: begin
                w_req.op = alhf_pkg::ALU_ADD;
                w_req.b  = {{(alhf_pkg::TIME_W-alhf_pkg::HOLD_W){1'b0}}, r_hold};
            end
            S_F_GAP: begin
                w_req.a = r_gap_dl;
                w_req.b = r_tmp;
            end
            S_F_APR: begin
                w_req.a = r_apr_dl;
                w_req.b = r_tmp;
            end
            S_U_TMO: begin
                w_req.a = {{(alhf_pkg::TIME_W-alhf_pkg::HOLD_W){1'b0}}, r_tmo};
                w_req.b = r_tmp;
            end
            S_U_GAP: w_req.b = r_gap_dl;
            S_U_APR: w_req.b = r_apr_dl;
            S_U_DIF: w_req.b = r_fstart;
            S_U_DIV: begin
                w_req.a = {{(alhf_pkg::TIME_W-alhf_pkg::HALF_W-1){1'b0}}, w_shift};
                w_req.b = {{(alhf_pkg::TIME_W-alhf_pkg::HALF_W){1'b0}}, r_half};
            end
            default: begin
                w_req.a = r_now;
                w_req.b = r_last;
            end
        endcase
    end

    alhf_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    // control and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold     <= alhf_pkg::HOLD_RST;
            r_half     <= alhf_pkg::HALF_RST;
            r_tmo      <= alhf_pkg::TIMEOUT_RST;
            r_state    <= S_IDLE;
            r_last     <= '0;
            r_seen     <= 1'b0;
            r_gap_flag <= 1'b0;
            r_apr_flag <= 1'b0;
            r_gap_dl   <= '0;
            r_apr_dl   <= '0;
            r_fstart   <= '0;
            r_was      <= 1'b0;
            r_gap_lvl  <= 1'b0;
            r_spd_lvl  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    alhf_pkg::CFG_HOLD:    r_hold <= i_cfg_data;
                    alhf_pkg::CFG_HALF:    r_half <= i_cfg_data[alhf_pkg::HALF_W-1:0];
                    alhf_pkg::CFG_TIMEOUT: r_tmo  <= i_cfg_data;
                    default: ;
                endcase
            end

            // result slot drains unless refilled in S_OUT
            if (r_o_valid && i_ready && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        unique case (i_mode)
                            alhf_pkg::MODE_FRAME: begin
                                r_last     <= i_now_ns;
                                r_seen     <= 1'b1;
                                r_gap_flag <= i_gap_violation;
                                r_apr_flag <= i_approach_alert;
                                r_state    <= S_F_ADD;
                            end
                            alhf_pkg::MODE_UPDATE: r_state <= S_U_AGE;
                            alhf_pkg::MODE_OFF: begin
                                r_gap_dl   <= '0;
                                r_apr_dl   <= '0;
                                r_gap_flag <= 1'b0;
                                r_apr_flag <= 1'b0;
                                r_was      <= 1'b0;
                                r_state    <= S_OUT;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_F_ADD: r_state <= S_F_GAP;
                S_F_GAP: begin
                    // borrow means until is past the old deadline
                    if (r_gv && w_rsp.borrow) begin
                        r_gap_dl <= r_tmp;
                    end
                    r_state <= S_F_APR;
                end
                S_F_APR: begin
                    if (r_aa && w_rsp.borrow) begin
                        r_apr_dl <= r_tmp;
                    end
                    r_state <= S_IDLE;
                end
                S_U_AGE: r_state <= S_U_TMO;
                S_U_TMO: r_state <= S_U_GAP;
                S_U_GAP: r_state <= S_U_APR;
                S_U_APR: begin
                    if (w_appr && !r_was) begin
                        r_fstart <= r_now;
                    end
                    r_was <= w_appr;
                    if (w_appr && (r_half != '0)) begin
                        r_state <= S_U_DIF;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_U_DIF: r_state <= S_U_DIV;
                S_U_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_slot_free) begin
                        r_o_valid <= 1'b1;
                        r_gap_lvl <= r_gap_new;
                        r_spd_lvl <= r_spd_new;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // working and result payload registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_now     <= i_now_ns;
                r_gv      <= i_gap_violation;
                r_aa      <= i_approach_alert;
                r_gap_new <= 1'b0;
                r_spd_new <= 1'b0;
            end
            S_F_ADD: r_tmp <= w_rsp.result;
            S_U_AGE: begin
                r_tmp  <= w_rsp.result;
                r_back <= w_rsp.borrow;    // time went backwards
            end
            S_U_TMO: r_alive <= r_seen & ~r_back & ~w_rsp.borrow;
            S_U_GAP: r_gap_new <= r_alive & (r_gap_flag | w_rsp.borrow);
            S_U_APR: r_spd_new <= w_appr;  // steady on unless a flash divide follows
            S_U_DIF: begin
                r_tmp <= w_rsp.result;
                r_rem <= '0;
                r_cnt <= '1;
            end
            S_U_DIV: begin
                r_tmp <= {r_tmp[alhf_pkg::TIME_W-2:0], 1'b0};
                r_rem <= w_rsp.borrow ? w_shift[alhf_pkg::HALF_W-1:0]
                                      : w_rsp.result[alhf_pkg::HALF_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                // last quotient bit: even quotient means on
                if (r_cnt == '0) begin
                    r_spd_new <= w_rsp.borrow;
                end
            end
            S_OUT: begin
                if (w_slot_free) begin
                    r_o_gap     <= r_gap_new;
                    r_o_spd     <= r_spd_new;
                    r_o_gap_chg <= r_gap_new ^ r_gap_lvl;
                    r_o_spd_chg <= r_spd_new ^ r_spd_lvl;
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/core/alhf_checker.sv -----
// ----------------------------------------------------------------------------
// alhf_checker
// port-level checks of the alert led controller, bound to the top level
// ----------------------------------------------------------------------------
module alhf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic [alhf_pkg::MODE_W-1:0] i_mode,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic                        o_gap_led,
    input logic                        o_speed_led,
    input logic                        o_gap_changed,
    input logic                        o_speed_changed
);

    // led levels as last delivered
    logic r_prev_gap;
    logic r_prev_spd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_gap <= 1'b0;
            r_prev_spd <= 1'b0;
        end else if (o_valid && i_ready) begin
            r_prev_gap <= o_gap_led;
            r_prev_spd <= o_speed_led;
        end
    end

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_gap_led) && $stable(o_speed_led)
            && $stable(o_gap_changed) && $stable(o_speed_changed)))
        else $error("stalled result beat changed");

    // a frame, update or all-off beat keeps the block busy next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && ((i_mode == alhf_pkg::MODE_FRAME)
            || (i_mode == alhf_pkg::MODE_UPDATE) || (i_mode == alhf_pkg::MODE_OFF)))
        |=> !o_ready)
        else $error("ready right after a working beat");

    // change marks follow the delivered levels
    a_gap_chg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_gap_changed == (o_gap_led ^ r_prev_gap)))
        else $error("gap change mark wrong");

    a_spd_chg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_speed_changed == (o_speed_led ^ r_prev_spd)))
        else $error("speed change mark wrong");

endmodule

bind alert_led_hold_flash_controller alhf_checker u_alhf_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the alert led hold and flash controller: a directed
// table of frame, update and all-off beats, then phases of random timestamped
// traffic under several register settings and idle patterns, every result
// beat compared against the table's own leds or a behavioral led predictor
// ----------------------------------------------------------------------------
module tb_top;

    // mode 3 and register index 3 are legal on the wires but do nothing
    localparam logic [alhf_pkg::MODE_W-1:0]    MODE_UNUSED = 2'd3;
    localparam logic [alhf_pkg::CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    localparam int DIR_ROWS        = 25;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int PAUSE_EVERY     = 60;
    // slowest beat is a flashing update with its divide steps, so this covers any beat still in flight
    localparam int LATENCY_PAD     = 100;
    // slowest beat plus long random stalls on both sides, several times over
    localparam int WATCHDOG_LIMIT  = 4000;

    localparam logic [alhf_pkg::TIME_W-1:0] T_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    // one led result beat; first member is the msb
    typedef struct packed {
        logic gap;
        logic speed;
        logic gap_chg;
        logic speed_chg;
    } t_leds;

    // one row of the directed table; leds is used only when typed is set
    typedef struct packed {
        logic [alhf_pkg::MODE_W-1:0] mode;
        logic [alhf_pkg::TIME_W-1:0] now;
        logic                        gv;
        logic                        aa;
        logic                        typed;
        t_leds                       leds;
    } t_row;

    // ------------------------------------------------------------------------
    // block ports, all inputs driven to known values from time zero
    // ------------------------------------------------------------------------
    logic                           i_clk            = 1'b0;
    logic                           i_rst_n          = 1'b0;
    logic                           i_cfg_valid      = 1'b0;
    logic                           o_cfg_ready;
    logic [alhf_pkg::CFG_IDX_W-1:0] i_cfg_index      = '0;
    logic [alhf_pkg::CFG_DAT_W-1:0] i_cfg_data       = '0;
    logic                           i_valid          = 1'b0;
    logic                           o_ready;
    logic [alhf_pkg::MODE_W-1:0]    i_mode           = alhf_pkg::MODE_FRAME;
    logic [alhf_pkg::TIME_W-1:0]    i_now_ns         = '0;
    logic                           i_gap_violation  = 1'b0;
    logic                           i_approach_alert = 1'b0;
    logic                           o_valid;
    logic                           i_ready          = 1'b0;
    logic                           o_gap_led;
    logic                           o_speed_led;
    logic                           o_gap_changed;
    logic                           o_speed_changed;

    alert_led_hold_flash_controller DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_now_ns         (i_now_ns),
        .i_gap_violation  (i_gap_violation),
        .i_approach_alert (i_approach_alert),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_gap_led        (o_gap_led),
        .o_speed_led      (o_speed_led),
        .o_gap_changed    (o_gap_changed),
        .o_speed_changed  (o_speed_changed)
    );

    // 10 ns clock
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // predictor state: register copies and the controller's own state
    // ------------------------------------------------------------------------
    logic [alhf_pkg::HOLD_W-1:0] cfg_hold    = alhf_pkg::HOLD_RST;
    logic [alhf_pkg::HALF_W-1:0] cfg_half    = alhf_pkg::HALF_RST;
    logic [alhf_pkg::HOLD_W-1:0] cfg_timeout = alhf_pkg::TIMEOUT_RST;

    logic [alhf_pkg::TIME_W-1:0] frm_time    = '0;
    logic                        frm_seen    = 1'b0;
    logic                        frm_gap     = 1'b0;
    logic                        frm_appr    = 1'b0;
    logic [alhf_pkg::TIME_W-1:0] gap_until   = '0;
    logic [alhf_pkg::TIME_W-1:0] appr_until  = '0;
    logic [alhf_pkg::TIME_W-1:0] flash_t0    = '0;
    logic                        appr_active = 1'b0;
    logic                        gap_lvl     = 1'b0;
    logic                        speed_lvl   = 1'b0;

    // led beats still owed by the block, oldest first
    t_leds pending_leds [$];

    int          n_errors     = 0;
    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    int unsigned quiet_cycles = 0;

    // directed table, default registers after reset
    t_row dir_table [0:DIR_ROWS-1] = '{
        // nothing seen yet: update and all-off both leave the leds dark
        '{alhf_pkg::MODE_UPDATE, 64'd0, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0}},
        '{alhf_pkg::MODE_OFF,    64'd0, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0}},
        // unused mode at the top timestamp, no beat back
        '{MODE_UNUSED, T_MAX, 1'b1, 1'b1, 1'b0, '{1'b0, 1'b0, 1'b0, 1'b0}},
        // both flags, then the flash walks through two half periods
        '{alhf_pkg::MODE_FRAME,  64'd1000, 1'b1, 1'b1, 1'b0,
            '{1'b0, 1'b0, 1'b0, 1'b0}},
        '{alhf_pkg::MODE_UPDATE, 64'd1000, 1'b0, 1'b0, 1'b1,
            '{1'b1, 1'b1, 1'b1, 1'b1}},
        '{alhf_pkg::MODE_UPDATE, 64'd250001000, 1'b0, 1'b0, 1'b1,
            '{1'b1, 1'b0, 1'b0, 1'b1}},
        '{alhf_pkg::MODE_UPDATE, 64'd500001000, 1'b0, 1'b0, 1'b1,
            '{1'b1, 1'b1, 1'b0, 1'b1}},
        // flags dropped, hold deadline carries the alerts to its edge
        '{alhf_pkg::MODE_FRAME,  64'd2000, 1'b0, 1'b0, 1'b0,
            '{1'b0, 1'b0, 1'b0, 1'b0}},
        '{alhf_pkg::MODE_UPDATE, 64'd500000999, 1'b0, 1'b0, 1'b0,
            '{1'b0, 1'b0, 1'b0, 1'b0}},
        '{alhf_pkg::MODE_UPDATE, 64'd500001000, 1'b0, 1'b0, 1'b0,
            '{1'b0, 1'b0, 1'b0, 1'b0}},
        // time going backwards, then frame age right at and past the timeout
        '{alhf_pkg::MODE_FRAME,  64'd1000000000000, 1'b1, 1'b1, 1'b0,
            '{1'b0, 1'b0, 1'b0, 1'b0}},
        '{alhf_pkg::MODE_UPDATE, 64'd999999999999, 1'b0, 1'b0, 1'b0,
            '{1'b0, 1'b0, 1'b0, 1'b0}},
        '{alhf_pkg::MODE_UPDATE, 64'd1001000000000, 1'b0, 1'b0, 1'b0,
            '{1'b0, 1'b0, 1'b0, 1'b0}},
        '{alhf_pkg::MODE_UPDATE, 64'd1001000000001, 1'b0, 1'b0, 1'b0,
            '{1'b0, 1'b0, 1'b0, 1'b0}},
        '{alhf_pkg::MODE_OFF,    64'd1001000000002, 1'b0, 1'b0, 1'b0,
            '{1'b0, 1'b0, 1'b0, 1'b0}},
        // deadline sum wraps past 2^64
        '{alhf_pkg::MODE_FRAME,  64'hFFFF_FFFF_FFFF_FF9C, 1'b1, 1'b0, 1'b0,
            '{1'b0, 1'b0, 1'b0, 1'b0}},
        '{alhf_pkg::MODE_UPDATE, 64'hFFFF_FFFF_FFFF_FFCE, 1'b0, 1'b0, 1'b0,
            '{1'b0, 1'b0, 1'b0, 1'b0}},
        '{alhf_pkg::MODE_FRAME,  64'hFFFF_FFFF_FFFF_FFF6, 1'b0, 1'b1, 1'b0,
            '{1'b0, 1'b0, 1'b0, 1'b0}},
        '{alhf_pkg::MODE_UPDATE, 64'd5, 1'b0, 1'b0, 1'b0,
            '{1'b0, 1'b0, 1'b0, 1'b0}},
        // flash difference wraps: update earlier than the flash start
        '{alhf_pkg::MODE_FRAME,  64'd100, 1'b0, 1'b1, 1'b0,
            '{1'b0, 1'b0, 1'b0, 1'b0}},
        '{alhf_pkg::MODE_UPDATE, 64'd1000, 1'b0, 1'b0, 1'b0,
            '{1'b0, 1'b0, 1'b0, 1'b0}},
        '{alhf_pkg::MODE_UPDATE, 64'd500, 1'b0, 1'b0, 1'b0,
            '{1'b0, 1'b0, 1'b0, 1'b0}},
        // top timestamp on every path
        '{alhf_pkg::MODE_FRAME,  T_MAX, 1'b1, 1'b1, 1'b0, '{1'b0, 1'b0, 1'b0, 1'b0}},
        '{alhf_pkg::MODE_UPDATE, T_MAX, 1'b0, 1'b0, 1'b0, '{1'b0, 1'b0, 1'b0, 1'b0}},
        '{alhf_pkg::MODE_OFF,    T_MAX, 1'b0, 1'b0, 1'b0, '{1'b0, 1'b0, 1'b0, 1'b0}}
    };

    // ------------------------------------------------------------------------
    // led predictor: advances the controller state by one accepted beat
    // ------------------------------------------------------------------------
    task automatic predict_leds(input logic [alhf_pkg::MODE_W-1:0] mode,
                                input logic [alhf_pkg::TIME_W-1:0] now,
                                input logic gv, input logic aa,
                                output logic yields, output t_leds leds);
        logic [alhf_pkg::TIME_W-1:0] hold_end;
        logic [alhf_pkg::TIME_W-1:0] quot;
        logic                        alive;
        logic                        gap_on;
        logic                        appr_on;
        logic                        speed_on;
        yields   = 1'b0;
        leds     = '0;
        gap_on   = 1'b0;
        speed_on = 1'b0;
        // sum wraps modulo 2^64
        hold_end = now + {24'd0, cfg_hold};
        // a frame from the future counts as timed out
        alive = frm_seen && (now >= frm_time) &&
                ((now - frm_time) <= {24'd0, cfg_timeout});
        case (mode)
            alhf_pkg::MODE_FRAME: begin
                frm_time = now;
                frm_seen = 1'b1;
                frm_gap  = gv;
                frm_appr = aa;
                if (gv && hold_end > gap_until)
                    gap_until = hold_end;
                if (aa && hold_end > appr_until)
                    appr_until = hold_end;
            end
            alhf_pkg::MODE_UPDATE: begin
                yields  = 1'b1;
                gap_on  = alive && (frm_gap || now < gap_until);
                appr_on = alive && (frm_appr || now < appr_until);
                // flash phase restarts on the rising edge of the approach alert
                if (appr_on && !appr_active)
                    flash_t0 = now;
                appr_active = appr_on;
                if (appr_on) begin
                    if (cfg_half == '0) begin
                        speed_on = 1'b1;
                    end else begin
                        quot     = (now - flash_t0) / {32'd0, cfg_half};
                        speed_on = ~quot[0];
                    end
                end
            end
            alhf_pkg::MODE_OFF: begin
                // frame time and frame_seen survive an all-off
                yields      = 1'b1;
                gap_until   = '0;
                appr_until  = '0;
                frm_gap     = 1'b0;
                frm_appr    = 1'b0;
                appr_active = 1'b0;
            end
            default: ;
        endcase
        if (yields) begin
            leds      = '{gap_on, speed_on, gap_on != gap_lvl, speed_on != speed_lvl};
            gap_lvl   = gap_on;
            speed_lvl = speed_on;
        end
    endtask

    // ------------------------------------------------------------------------
    // sender: one input beat, with random idle cycles ahead of it
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic [alhf_pkg::MODE_W-1:0] mode,
                             input logic [alhf_pkg::TIME_W-1:0] now,
                             input logic gv, input logic aa,
                             input logic typed, input t_leds typed_leds);
        logic  yields;
        t_leds leds;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        i_valid          <= 1'b1;
        i_mode           <= mode;
        i_now_ns         <= now;
        i_gap_violation  <= gv;
        i_approach_alert <= aa;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        // accepted at this edge
        predict_leds(mode, now, gv, aa, yields, leds);
        if (yields)
            pending_leds.push_back(typed ? typed_leds : leds);
    endtask

    // stop sending and wait for every owed result beat
    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (pending_leds.size() != 0) @(posedge i_clk);
    endtask

    // writes the three registers, optionally poking the unused index too
    task automatic program_regs(input logic [alhf_pkg::CFG_DAT_W-1:0] hold,
                                input logic [alhf_pkg::CFG_DAT_W-1:0] half,
                                input logic [alhf_pkg::CFG_DAT_W-1:0] timeout,
                                input logic poke_unused);
        logic [alhf_pkg::CFG_DAT_W-1:0] data;
        logic [alhf_pkg::CFG_IDX_W-1:0] idx;
        for (int k = 0; k < (poke_unused ? 4 : 3); k++) begin
            idx = alhf_pkg::CFG_IDX_W'(k);
            case (idx)
                alhf_pkg::CFG_HOLD:    data = hold;
                alhf_pkg::CFG_HALF:    data = half;
                alhf_pkg::CFG_TIMEOUT: data = timeout;
                default:               data = alhf_pkg::CFG_DAT_W'({$urandom, $urandom});
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= data;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (idx)
                alhf_pkg::CFG_HOLD:    cfg_hold    = data;
                alhf_pkg::CFG_HALF:    cfg_half    = data[alhf_pkg::HALF_W-1:0];
                alhf_pkg::CFG_TIMEOUT: cfg_timeout = data;
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // receiver: random back-pressure on the result channel
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // ------------------------------------------------------------------------
    // result checker: every accepted result beat against the oldest owed one
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_leds got;
        t_leds want;
        string field_names [4];
        field_names = '{"speed_changed", "gap_changed", "speed_led", "gap_led"};
        got = '{o_gap_led, o_speed_led, o_gap_changed, o_speed_changed};
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_leds.size() == 0) begin
                n_errors++;
                $display("%0t result beat with none owed: got %b", $time, got);
            end else begin
                want = pending_leds.pop_front();
                for (int b = 0; b < 4; b++) begin
                    if (got[b] !== want[b]) begin
                        n_errors++;
                        $display("%0t %s mismatch: expected %b actual %b",
                                 $time, field_names[b], want[b], got[b]);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too many cycles with no beat on any channel ends the run
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (i_cfg_valid && o_cfg_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [alhf_pkg::TIME_W-1:0]    t_cur;
        logic [alhf_pkg::TIME_W-1:0]    step;
        logic [alhf_pkg::MODE_W-1:0]    mode;
        logic [alhf_pkg::CFG_DAT_W-1:0] r_hold;
        logic [alhf_pkg::CFG_DAT_W-1:0] r_half;
        logic [alhf_pkg::CFG_DAT_W-1:0] r_timeout;
        logic                           poke;
        logic                           gv;
        logic                           aa;
        int                             r;

        // reset held low, released at an edge
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, registers at their reset values, no idling
        for (int n = 0; n < DIR_ROWS; n++)
            send_beat(dir_table[n].mode, dir_table[n].now, dir_table[n].gv,
                      dir_table[n].aa, dir_table[n].typed, dir_table[n].leds);

        t_cur = 64'd0;
        for (int p = 0; p < PHASES; p++) begin
            // registers change only once the block has gone quiet
            wait_results_done();
            repeat (LATENCY_PAD) @(posedge i_clk);

            poke = 1'b0;
            case (p)
                0: begin
                    r_hold    = alhf_pkg::CFG_DAT_W'(alhf_pkg::HOLD_RST);
                    r_half    = alhf_pkg::CFG_DAT_W'(alhf_pkg::HALF_RST);
                    r_timeout = alhf_pkg::CFG_DAT_W'(alhf_pkg::TIMEOUT_RST);
                end
                1: begin
                    // all zero: steady speed led, alive only at the frame time
                    r_hold    = '0;
                    r_half    = '0;
                    r_timeout = '0;
                end
                2: begin
                    r_hold    = '1;
                    r_half    = '1;
                    r_timeout = '1;
                end
                3: begin
                    r_hold    = alhf_pkg::CFG_DAT_W'($urandom_range(0, 5000));
                    r_half    = {8'($urandom), 32'($urandom_range(1, 1000))};
                    r_timeout = alhf_pkg::CFG_DAT_W'($urandom_range(0, 8000));
                end
                4: begin
                    r_hold    = alhf_pkg::CFG_DAT_W'(1);
                    r_half    = alhf_pkg::CFG_DAT_W'(1);
                    r_timeout = alhf_pkg::CFG_DAT_W'(1);
                end
                5: begin
                    r_hold    = alhf_pkg::CFG_DAT_W'({$urandom, $urandom});
                    r_half    = alhf_pkg::CFG_DAT_W'({$urandom, $urandom});
                    r_timeout = alhf_pkg::CFG_DAT_W'({$urandom, $urandom});
                end
                6: begin
                    r_hold    = alhf_pkg::CFG_DAT_W'($urandom_range(0, 3000));
                    r_half    = {8'($urandom), 32'($urandom_range(0, 700))};
                    r_timeout = alhf_pkg::CFG_DAT_W'($urandom_range(0, 6000));
                    poke      = 1'b1;
                end
                default: begin
                    // steady speed led with upper data bits set, timeout at its largest value
                    r_hold    = alhf_pkg::CFG_DAT_W'($urandom_range(0, 4000));
                    r_half    = {8'($urandom), 32'd0};
                    r_timeout = '1;
                end
            endcase
            program_regs(r_hold, r_half, r_timeout, poke);

            // idle pattern: none, sender, receiver, both
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 58; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 58; end
                default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
            endcase

            // time steps scaled to the settings so holds and timeouts both bite
            step = ({24'd0, cfg_hold} + {24'd0, cfg_timeout} + {31'd0, cfg_half, 1'b0}) / 2
                   + 64'd2;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // now and then let everything drain before sending more
                if (n % PAUSE_EVERY == PAUSE_EVERY - 1) begin
                    wait_results_done();
                    @(posedge i_clk);
                end

                r = $urandom_range(0, 99);
                if (r < 40)      mode = alhf_pkg::MODE_FRAME;
                else if (r < 88) mode = alhf_pkg::MODE_UPDATE;
                else if (r < 94) mode = alhf_pkg::MODE_OFF;
                else if (r < 96) mode = MODE_UNUSED;
                else             mode = alhf_pkg::MODE_W'($urandom);

                r = $urandom_range(0, 99);
                if (r < 4)
                    t_cur = {$urandom, $urandom};
                else if (r < 7)
                    t_cur = T_MAX - ({$urandom, $urandom} % (step + 64'd1));
                else if (r < 12)
                    t_cur = t_cur - ({$urandom, $urandom} % (step + 64'd1));
                else
                    t_cur = t_cur + ({$urandom, $urandom} % (step + 64'd1));

                gv = 1'($urandom_range(0, 1));
                aa = 1'($urandom_range(0, 1));
                send_beat(mode, t_cur, gv, aa, 1'b0, '0);
            end
        end

        // drain, then let any frame beat still in flight settle
        wait_results_done();
        repeat (LATENCY_PAD) @(posedge i_clk);
        if (n_errors == 0 && pending_leds.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/alhf_pkg.sv
rtl/core/alhf_alu.sv
rtl/core/alert_led_hold_flash_controller.sv
rtl/core/alhf_checker.sv
tb/tb_top.sv
